// ===== design/fixed_step_steer_2d_assert.svh =====
// ----------------------------------------------------------------------------
// fixed_step_steer_2d assertion macros
// Shorthand for clocked assertions; expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef FIXED_STEP_STEER_2D_ASSERT_SVH
`define FIXED_STEP_STEER_2D_ASSERT_SVH

// same-cycle implication
`define FFSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ffss_pkg.sv =====
// ----------------------------------------------------------------------------
// ffss_pkg
// Types and constants shared by the fixed-step steering pipeline.
// ----------------------------------------------------------------------------
package ffss_pkg;

  localparam int COORD_BITS        = 32;
  localparam int STEP_BITS         = 31;
  localparam int GUARD_BITS        = 16;
  localparam int CORDIC_STAGES_DEF = 18;

  // CORDIC inverse gain, Q0.32
  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int SQ_BITS      = 2 * COORD_BITS;
  localparam int DSQ_BITS     = SQ_BITS + 1;
  localparam int STEP_SQ_BITS = 2 * STEP_BITS;
  localparam int U0_BITS      = STEP_BITS + 32 - GUARD_BITS;
  localparam int XW           = COORD_BITS + 4;
  localparam int UW           = U0_BITS + 3;
  localparam int RW           = UW - GUARD_BITS;

  localparam logic [STEP_BITS-1:0]    STEP_RESET    = STEP_BITS'(65536);
  localparam logic [STEP_SQ_BITS-1:0] STEP_SQ_RESET =
    STEP_SQ_BITS'(64'(STEP_RESET) * 64'(STEP_RESET));
  localparam logic [U0_BITS-1:0]      U0_RESET      =
    U0_BITS'((64'(STEP_RESET) * 64'(INV_GAIN)) >> GUARD_BITS);

  typedef enum logic [1:0] {
    QUAD_NONE,
    QUAD_POS,
    QUAD_NEG
  } quad_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] parent_x;
    logic signed [COORD_BITS-1:0] parent_y;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic                         last_agent;
  } ffss_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] new_x;
    logic signed [COORD_BITS-1:0] new_y;
    logic                         reached;
    logic                         last_agent_out;
  } ffss_out_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [UW-1:0] u;
    logic signed [UW-1:0] v;
    quad_t                quad;
    logic                 in_reach;
    ffss_in_t             req;
  } ffss_cordic_t;

endpackage

// ===== design/fixed_step_steer_2d.sv =====
// ----------------------------------------------------------------------------
// fixed_step_steer_2d
// Steers a parent point one fixed step toward a target point, or returns the
// target when it lies strictly closer than the step length.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in_      | input     | in_valid / in_ready  | ffss_in_t  (parent, target, mark)
//  out_     | output    | out_valid / out_ready| ffss_out_t (point, reached, mark)
//  cfg_     | input     | cfg_wr_en            | cfg_wr_data (step length)
//
//  One request per cycle sustained while out_ready is high; the stages in
//  order are capture/difference, squares, distance compare, the CORDIC
//  stages, rounding, final add with saturation.
//  Each stage holds only while it is full and the stage after it holds, so
//  bubbles close up under a stall and in_ready falls only when every stage
//  is full and out_ready is low.
//  Reset is synchronous, clears the valid bits and sets the step length
//  to 1.0; derived step terms are registered from the stored step length.
// ----------------------------------------------------------------------------
`include "fixed_step_steer_2d_assert.svh"

module fixed_step_steer_2d #(
  parameter int CORDIC_STAGES = ffss_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ffss_pkg::ffss_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ffss_pkg::ffss_out_t              out_data,
  input  logic                             cfg_wr_en,
  input  logic [ffss_pkg::STEP_BITS-1:0]   cfg_wr_data
);
  import ffss_pkg::*;

  localparam int NSTG    = CORDIC_STAGES + 5;
  localparam int IDX_IN  = 0;
  localparam int IDX_SQ  = 1;
  localparam int IDX_CMP = 2;
  localparam int IDX_RND = CORDIC_STAGES + 3;
  localparam int IDX_OUT = CORDIC_STAGES + 4;

  localparam logic [UW-1:0] RND_HALF = UW'(1) << (GUARD_BITS - 1);
  localparam logic [UW-1:0] RND_NEG  = RND_HALF + UW'(1);

  // ---------------- step length and derived terms ----------------
  logic [STEP_BITS-1:0]      step_r;
  logic [STEP_SQ_BITS-1:0]   step_sq_r;
  logic [STEP_SQ_BITS-1:0]   step_sq_nxt;
  logic [U0_BITS-1:0]        u0_r;
  logic [U0_BITS-1:0]        u0_nxt;
  logic [STEP_BITS+31:0]     gain_prod;

  assign step_sq_nxt = STEP_SQ_BITS'(step_r) * STEP_SQ_BITS'(step_r);
  assign gain_prod   = (STEP_BITS + 32)'(step_r) * (STEP_BITS + 32)'(INV_GAIN);
  assign u0_nxt      = gain_prod[STEP_BITS+31:GUARD_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= STEP_RESET;
      step_sq_r <= STEP_SQ_RESET;
      u0_r      <= U0_RESET;
    end else begin
      if (cfg_wr_en) begin
        step_r <= cfg_wr_data;
      end
      step_sq_r <= step_sq_nxt;
      u0_r      <= u0_nxt;
    end
  end

  // ---------------- stage valids and enables ----------------
  logic [NSTG-1:0] valid_r;
  logic [NSTG-1:0] valid_nxt;
  logic [NSTG-1:0] valid_prev;
  logic [NSTG-1:0] en;
  logic [NSTG-1:0] holes;
  logic            in_acc;
  logic            out_acc;

  assign holes      = ~valid_r;
  assign valid_prev = {valid_r[NSTG-2:0], in_valid};

  // a stage may load when out_ready is high or when it, or any stage downstream, is empty
  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      en[k] = out_ready || (|(holes >> k));
    end
    valid_nxt = (en & valid_prev) | (~en & valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = en[IDX_IN];
  assign out_valid = valid_r[IDX_OUT];
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // ---------------- capture and difference ----------------
  ffss_in_t                     in_r;
  logic signed [DIFF_BITS-1:0]  dx_r;
  logic signed [DIFF_BITS-1:0]  dy_r;

  always_ff @(posedge clk) begin
    if (en[IDX_IN]) begin
      in_r <= in_data;
      dx_r <= {in_data.target_x[COORD_BITS-1], in_data.target_x}
            - {in_data.parent_x[COORD_BITS-1], in_data.parent_x};
      dy_r <= {in_data.target_y[COORD_BITS-1], in_data.target_y}
            - {in_data.parent_y[COORD_BITS-1], in_data.parent_y};
    end
  end

  // ---------------- squares and quadrant pre-rotation ----------------
  logic signed [2*DIFF_BITS-1:0] dx_prod;
  logic signed [2*DIFF_BITS-1:0] dy_prod;
  logic signed [XW-1:0]          xe;
  logic signed [XW-1:0]          ye;
  logic signed [XW-1:0]          rot_x_nxt;
  logic signed [XW-1:0]          rot_y_nxt;
  quad_t                         quad_nxt;

  ffss_in_t                      sq_req_r;
  logic [SQ_BITS-1:0]            dxsq_r;
  logic [SQ_BITS-1:0]            dysq_r;
  logic signed [XW-1:0]          rot_x_r;
  logic signed [XW-1:0]          rot_y_r;
  quad_t                         quad_r;

  assign dx_prod = dx_r * dx_r;
  assign dy_prod = dy_r * dy_r;

  always_comb begin
    xe        = XW'(dx_r);
    ye        = XW'(dy_r);
    rot_x_nxt = xe;
    rot_y_nxt = ye;
    quad_nxt  = QUAD_NONE;
    // turn the left half plane into the right one
    if (dx_r[DIFF_BITS-1]) begin
      if (!dy_r[DIFF_BITS-1]) begin
        rot_x_nxt = ye;
        rot_y_nxt = -xe;
        quad_nxt  = QUAD_POS;
      end else begin
        rot_x_nxt = -ye;
        rot_y_nxt = xe;
        quad_nxt  = QUAD_NEG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[IDX_SQ]) begin
      sq_req_r <= in_r;
      dxsq_r   <= dx_prod[SQ_BITS-1:0];
      dysq_r   <= dy_prod[SQ_BITS-1:0];
      rot_x_r  <= rot_x_nxt;
      rot_y_r  <= rot_y_nxt;
      quad_r   <= quad_nxt;
    end
  end

  // ---------------- distance compare, CORDIC seed ----------------
  logic [DSQ_BITS-1:0] dist_sq;
  ffss_cordic_t        cmp_nxt;
  ffss_cordic_t        cmp_r;

  assign dist_sq = {1'b0, dxsq_r} + {1'b0, dysq_r};

  always_comb begin
    cmp_nxt.x        = rot_x_r;
    cmp_nxt.y        = rot_y_r;
    cmp_nxt.u        = UW'(u0_r);
    cmp_nxt.v        = '0;
    cmp_nxt.quad     = quad_r;
    cmp_nxt.in_reach = dist_sq < DSQ_BITS'(step_sq_r);
    cmp_nxt.req      = sq_req_r;
  end

  always_ff @(posedge clk) begin
    if (en[IDX_CMP]) begin
      cmp_r <= cmp_nxt;
    end
  end

  // ---------------- CORDIC pipeline ----------------
  ffss_cordic_t cdc [CORDIC_STAGES+1];

  assign cdc[0] = cmp_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    ffss_cordic_stage #(
      .SHIFT(i)
    ) u_stage (
      .clk      (clk),
      .en       (en[IDX_CMP+1+i]),
      .stage_in (cdc[i]),
      .stage_out(cdc[i+1])
    );
  end

  // ---------------- undo pre-rotation, round ----------------
  ffss_cordic_t         cend;
  logic [UW-1:0]        sel_u;
  logic [UW-1:0]        sel_v;
  logic [UW-1:0]        add_u;
  logic [UW-1:0]        add_v;
  logic [UW-1:0]        sum_u;
  logic [UW-1:0]        sum_v;

  ffss_in_t             rnd_req_r;
  logic                 rnd_within_r;
  logic signed [RW-1:0] rnd_u_r;
  logic signed [RW-1:0] rnd_v_r;

  assign cend = cdc[CORDIC_STAGES];

  // negation folds into the rounding add: -a + h == ~a + (h + 1)
  always_comb begin
    case (cend.quad)
      QUAD_POS: begin
        sel_u = ~cend.v;
        add_u = RND_NEG;
        sel_v = cend.u;
        add_v = RND_HALF;
      end
      QUAD_NEG: begin
        sel_u = cend.v;
        add_u = RND_HALF;
        sel_v = ~cend.u;
        add_v = RND_NEG;
      end
      default: begin
        sel_u = cend.u;
        add_u = RND_HALF;
        sel_v = cend.v;
        add_v = RND_HALF;
      end
    endcase
    sum_u = sel_u + add_u;
    sum_v = sel_v + add_v;
  end

  always_ff @(posedge clk) begin
    if (en[IDX_RND]) begin
      rnd_req_r    <= cend.req;
      rnd_within_r <= cend.in_reach;
      rnd_u_r      <= sum_u[UW-1:GUARD_BITS];
      rnd_v_r      <= sum_v[UW-1:GUARD_BITS];
    end
  end

  // ---------------- final add, saturate ----------------
  function automatic logic [COORD_BITS-1:0] sat_coord(input logic [RW:0] s);
    logic [COORD_BITS-1:0] res;
    if (!s[RW] && (|s[RW-1:COORD_BITS-1])) begin
      res = {1'b0, {(COORD_BITS-1){1'b1}}};
    end else if (s[RW] && !(&s[RW-1:COORD_BITS-1])) begin
      res = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      res = s[COORD_BITS-1:0];
    end
    return res;
  endfunction

  logic [RW:0] fin_x;
  logic [RW:0] fin_y;
  ffss_out_t   out_nxt;
  ffss_out_t   out_r;

  always_comb begin
    fin_x = (RW + 1)'(rnd_req_r.parent_x) + (RW + 1)'(rnd_u_r);
    fin_y = (RW + 1)'(rnd_req_r.parent_y) + (RW + 1)'(rnd_v_r);
    out_nxt.last_agent_out = rnd_req_r.last_agent;
    out_nxt.reached        = rnd_within_r;
    if (rnd_within_r) begin
      out_nxt.new_x = rnd_req_r.target_x;
      out_nxt.new_y = rnd_req_r.target_y;
    end else begin
      out_nxt.new_x = sat_coord(fin_x);
      out_nxt.new_y = sat_coord(fin_y);
    end
  end

  always_ff @(posedge clk) begin
    if (en[IDX_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // ---------------- assertions ----------------
  `FFSS_ASSERT_IMP(a_full_stall, (&valid_r) && !out_ready, !in_ready,
    "full pipeline took a request")
  `FFSS_ASSERT_NXT(a_occupancy, rst_n,
    $countones(valid_r) == $past($countones(valid_r)) + int'($past(in_acc))
      - int'($past(out_acc)),
    "request lost or duplicated in pipeline")
  `FFSS_ASSERT_IMP(a_zero_step, valid_r[IDX_CMP] && cmp_r.in_reach, step_sq_r != '0,
    "zero step flagged as reached")
  `FFSS_ASSERT_IMP(a_right_half, valid_r[IDX_CMP], !cmp_r.x[XW-1],
    "pre-rotation left x negative")

endmodule

// ===== design/ffss_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// ffss_cordic_stage
// One registered CORDIC micro-rotation: vectors (x, y) toward the x axis and
// turns the step vector (u, v) by the same decision.
// ----------------------------------------------------------------------------
module ffss_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  ffss_pkg::ffss_cordic_t stage_in,
  output ffss_pkg::ffss_cordic_t stage_out
);
  import ffss_pkg::*;

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [UW-1:0] us;
  logic signed [UW-1:0] vs;
  logic                 pos;
  ffss_cordic_t         stage_nxt;
  ffss_cordic_t         stage_r;

  always_comb begin
    xs  = $signed(stage_in.x) >>> SHIFT;
    ys  = $signed(stage_in.y) >>> SHIFT;
    us  = $signed(stage_in.u) >>> SHIFT;
    vs  = $signed(stage_in.v) >>> SHIFT;
    pos = !stage_in.y[XW-1];
    stage_nxt = stage_in;
    if (pos) begin
      stage_nxt.x = stage_in.x + ys;
      stage_nxt.y = stage_in.y - xs;
      stage_nxt.u = stage_in.u - vs;
      stage_nxt.v = stage_in.v + us;
    end else begin
      stage_nxt.x = stage_in.x - ys;
      stage_nxt.y = stage_in.y + xs;
      stage_nxt.u = stage_in.u + vs;
      stage_nxt.v = stage_in.v - us;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule

// ===== dv/fixed_step_steer_2d_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_step_steer_2d_test
// Drives parent/target requests with random idling on both sides, predicts
// each steered point with an independent fixed-point CORDIC, and checks every
// result in order. The step length is changed between phases, including zero
// and full scale.
// ----------------------------------------------------------------------------
module fixed_step_steer_2d_test;
  import ffss_pkg::*;

  localparam int          STAGES          = 18;
  localparam int          ITEMS_PER_PHASE = 325;
  localparam int          NUM_PHASES      = 6;
  localparam int          WATCHDOG_LIMIT  = 1000;
  localparam int          SETTLE_CYCLES   = 30;
  localparam logic [63:0] INV_GAIN_Q32    = 64'h9B74_EDA8;
  localparam logic [31:0] CMAX            = 32'h7FFF_FFFF;
  localparam logic [31:0] CMIN            = 32'h8000_0000;
  localparam logic [31:0] ONE             = 32'd65536;
  localparam logic [30:0] STEP_MAX        = 31'h7FFF_FFFF;
  localparam logic [30:0] STEP_ONE        = 31'd65536;
  localparam longint      COORD_MAX       = 64'sd2147483647;
  localparam longint      COORD_MIN       = -64'sd2147483648;

  typedef struct packed {
    logic [30:0] step;
    ffss_in_t    req;
    logic        typed;
    ffss_out_t   want;
  } steer_case_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  ffss_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  ffss_out_t   out_data;
  logic        cfg_wr_en;
  logic [30:0] cfg_wr_data;

  ffss_out_t   expected_points[$];
  steer_case_t directed_cases[$];
  logic [30:0] step_now;
  int          mismatch_count;
  int          gap_pct;
  int          stall_pct;
  int          stall_left;
  int          stalled_cycles = 0;

  fixed_step_steer_2d #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [31:0] clamp_coord(input longint val);
    if (val > COORD_MAX) return CMAX;
    if (val < COORD_MIN) return CMIN;
    return val[31:0];
  endfunction

  // Steered point for one request at the given step length.
  function automatic ffss_out_t steer_point(input ffss_in_t req, input logic [30:0] step);
    longint           px, py, tx, ty, dx, dy, x, y, u, v, t, xs, ys, us, vs;
    logic [63:0]      ax, ay;
    logic [127:0]     dist_sq, step_sq;
    logic [STAGES-1:0] turn_ccw;
    quad_t            quad;
    ffss_out_t        res;
    px = $signed(req.parent_x);
    py = $signed(req.parent_y);
    tx = $signed(req.target_x);
    ty = $signed(req.target_y);
    dx = tx - px;
    dy = ty - py;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    dist_sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
    step_sq = 128'(step) * 128'(step);
    res.last_agent_out = req.last_agent;
    if (dist_sq < step_sq) begin
      res.new_x   = req.target_x;
      res.new_y   = req.target_y;
      res.reached = 1'b1;
      return res;
    end
    // fold the left half plane into the right one
    x = dx;
    y = dy;
    quad = QUAD_NONE;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; quad = QUAD_POS;
      end else begin
        t = x; x = -y; y = t; quad = QUAD_NEG;
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      turn_ccw[i] = (y >= 0);
      if (turn_ccw[i]) begin
        x = x + ys; y = y - xs;
      end else begin
        x = x - ys; y = y + xs;
      end
    end
    // replay the recorded turns on the gain-compensated step
    u = longint'((64'(step) * INV_GAIN_Q32) >> 16);
    v = 0;
    for (int i = 0; i < STAGES; i++) begin
      us = u >>> i;
      vs = v >>> i;
      if (turn_ccw[i]) begin
        u = u - vs; v = v + us;
      end else begin
        u = u + vs; v = v - us;
      end
    end
    if (quad == QUAD_POS) begin
      t = u; u = -v; v = t;
    end else if (quad == QUAD_NEG) begin
      t = u; u = v; v = -t;
    end
    u = (u + 32768) >>> 16;
    v = (v + 32768) >>> 16;
    res.new_x   = clamp_coord(px + u);
    res.new_y   = clamp_coord(py + v);
    res.reached = 1'b0;
    return res;
  endfunction

  function automatic ffss_in_t random_request(input logic [30:0] step);
    ffss_in_t           req;
    logic signed [31:0] rnd_x, rnd_y, edge_x, tmp;
    longint             px, py, dx, dy, swap;
    int unsigned        kind;
    req.parent_x   = $urandom;
    req.parent_y   = $urandom;
    req.last_agent = 1'($urandom_range(1));
    rnd_x = $urandom;
    rnd_y = $urandom;
    px = $signed(req.parent_x);
    py = $signed(req.parent_y);
    kind = $urandom_range(9);
    case (kind)
      0, 1: begin
        dx = longint'(rnd_x) - px;
        dy = longint'(rnd_y) - py;
      end
      2, 3, 4, 9: begin
        dx = longint'($urandom_range(step));
        dy = longint'($urandom_range(step));
      end
      5: begin
        // right at the step boundary along an axis
        dx = longint'(step) + longint'($urandom_range(2)) - 1;
        dy = 0;
      end
      6: begin
        // hug a coordinate limit so rounding can push past it
        edge_x = $urandom_range(1) ? CMAX : CMIN;
        req.parent_x = edge_x[31] ? edge_x + $urandom_range(15) : edge_x - $urandom_range(15);
        px = $signed(req.parent_x);
        dx = longint'(edge_x) - px;
        dy = longint'(rnd_y) - py;
      end
      default: begin
        dx = longint'($urandom_range(511)) - 256;
        dy = longint'($urandom_range(511)) - 256;
      end
    endcase
    if (kind != 6 && kind > 1) begin
      if ($urandom_range(1)) dx = -dx;
      if ($urandom_range(1)) dy = -dy;
    end
    if ($urandom_range(1)) begin
      tmp = req.parent_x; req.parent_x = req.parent_y; req.parent_y = tmp;
      swap = px; px = py; py = swap;
      swap = dx; dx = dy; dy = swap;
    end
    req.target_x = 32'(px + dx);
    req.target_y = 32'(py + dy);
    return req;
  endfunction

  function automatic void add_case(input logic [30:0] step,
                                   input logic [31:0] px, py, tx, ty,
                                   input logic last, input logic typed,
                                   input logic [31:0] wx, wy, input logic hit);
    steer_case_t c;
    c.step  = step;
    c.req   = {px, py, tx, ty, last};
    c.typed = typed;
    c.want  = {wx, wy, hit, last};
    directed_cases.insert(directed_cases.size(), c);
  endfunction

  task automatic send_request(input ffss_in_t req, input ffss_out_t want);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_points.insert(expected_points.size(), want);
    @(negedge clk);
  endtask

  // Write the step length once the pipeline has drained.
  task automatic set_step(input logic [30:0] value);
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    step_now = value;
    // derived step terms are registered behind the step length; let them settle
    repeat (2) @(negedge clk);
  endtask

  // Receiver stalls in bursts of random length.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    ffss_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        $error("result with no request pending: %h", out_data);
        mismatch_count++;
      end else begin
        want = expected_points.pop_front();
        if (out_data.new_x !== want.new_x) begin
          $error("new_x: expected %h, got %h", want.new_x, out_data.new_x);
          mismatch_count++;
        end
        if (out_data.new_y !== want.new_y) begin
          $error("new_y: expected %h, got %h", want.new_y, out_data.new_y);
          mismatch_count++;
        end
        if (out_data.reached !== want.reached) begin
          $error("reached: expected %b, got %b", want.reached, out_data.reached);
          mismatch_count++;
        end
        if (out_data.last_agent_out !== want.last_agent_out) begin
          $error("last_agent_out: expected %b, got %b", want.last_agent_out,
                 out_data.last_agent_out);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    ffss_in_t    req;
    steer_case_t c;
    logic [30:0] next_step;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    step_now       = STEP_ONE;
    mismatch_count = 0;
    gap_pct        = 20;
    stall_pct      = 20;
    stall_left     = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // step 1.0 from reset
    add_case(STEP_ONE, 0, 0, 0, 0, 0, 1, 0, 0, 1);
    add_case(STEP_ONE, 0, 0, 32768, 0, 1, 1, 32768, 0, 1);
    add_case(STEP_ONE, CMAX, CMAX, CMAX, CMAX, 1, 1, CMAX, CMAX, 1);
    add_case(STEP_ONE, CMIN, CMIN, CMIN, CMIN, 0, 1, CMIN, CMIN, 1);
    add_case(STEP_ONE, 0, 0, 65535, 0, 0, 1, 65535, 0, 1);
    add_case(STEP_ONE, 0, 0, ONE, 0, 1, 0, 0, 0, 0);
    add_case(STEP_ONE, 0, 0, 0, -ONE, 0, 0, 0, 0, 0);
    add_case(STEP_ONE, 0, 0, -5 * ONE, 3, 1, 0, 0, 0, 0);
    add_case(STEP_ONE, 0, 0, -5 * ONE, -3, 0, 0, 0, 0, 0);
    add_case(STEP_ONE, CMIN, CMIN, CMAX, CMAX, 1, 0, 0, 0, 0);
    add_case(STEP_ONE, CMAX, 0, CMIN, 0, 0, 0, 0, 0, 0);
    add_case(STEP_ONE, CMAX, 0, CMAX, CMAX, 1, 0, 0, 0, 0);
    add_case(STEP_ONE, CMAX, CMAX, CMIN, CMIN, 0, 0, 0, 0, 0);
    // zero step always returns the parent
    add_case(31'd0, 100, 200, 100, 200, 0, 1, 100, 200, 0);
    add_case(31'd0, 100, 200, CMIN, CMAX, 1, 1, 100, 200, 0);
    add_case(31'd0, CMAX, CMIN, CMIN, CMAX, 0, 1, CMAX, CMIN, 0);
    // smallest nonzero step
    add_case(31'd1, 0, 0, 0, 0, 0, 1, 0, 0, 1);
    add_case(31'd1, 0, 0, 1, 0, 1, 0, 0, 0, 0);
    add_case(31'd1, 0, 0, -1, -1, 0, 0, 0, 0, 0);
    // full-scale step
    add_case(STEP_MAX, CMIN, CMIN, CMAX, CMAX, 1, 0, 0, 0, 0);
    add_case(STEP_MAX, CMIN, 0, CMAX, 0, 0, 0, 0, 0, 0);
    add_case(STEP_MAX, 0, 0, CMAX, 0, 1, 0, 0, 0, 0);
    add_case(STEP_MAX, 0, 0, 0, CMIN, 0, 0, 0, 0, 0);
    add_case(STEP_MAX, 32'h7FFF_0000, 0, CMAX, CMIN, 1, 0, 0, 0, 0);
    add_case(STEP_MAX, 0, 0, 32'h4000_0000, 0, 0, 1, 32'h4000_0000, 0, 1);

    while (directed_cases.size() != 0) begin
      c = directed_cases.pop_front();
      if (c.step != step_now) set_step(c.step);
      send_request(c.req, c.typed ? c.want : steer_point(c.req, step_now));
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin next_step = STEP_MAX;              gap_pct = 25; stall_pct = 40; end
        1: begin
          next_step = 31'($urandom_range(1 << 20, 1));
          gap_pct   = 40;
          stall_pct = 10;
        end
        2: begin next_step = '0;                    gap_pct = 0;  stall_pct = 0;  end
        3: begin next_step = 31'd1;                 gap_pct = 10; stall_pct = 60; end
        4: begin next_step = 31'($urandom);         gap_pct = 50; stall_pct = 25; end
        default: begin next_step = 31'd196608;      gap_pct = 0;  stall_pct = 0;  end
      endcase
      set_step(next_step);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        req = random_request(step_now);
        send_request(req, steer_point(req, step_now));
      end
    end

    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_points.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
